>>> src/snl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package snl_pkg;

    localparam int LFSR_W  = 23;
    localparam int NOISE_W = 12;
    localparam int WAVE_W  = 4;
    localparam int COUNT_W = 16;

    localparam logic [1:0] OP_SHIFT = 2'd0;
    localparam logic [1:0] OP_CTRL  = 2'd1;
    localparam logic [1:0] OP_WB    = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [COUNT_W-1:0] RESET_DELAY = 16'h8000;
    localparam int TEST_BIT  = 3;
    localparam int NOISE_SEL = 3;
    localparam logic [NOISE_W-1:0] NOISE_OFF = 12'hfff;

    typedef struct packed {
        logic shift;
        logic feed;
        logic load_ones;
        logic wb_clear;
    } cell_cmd_t;

    function automatic logic [NOISE_W-1:0] gather_noise(input logic [LFSR_W-1:0] r);
        gather_noise = {r[2], r[4], r[8], r[11], r[13], r[17], r[20], r[22], 4'b0000};
    endfunction

    function automatic logic [LFSR_W-1:0] keep_mask(input logic [NOISE_W-1:0] w);
        logic [LFSR_W-1:0] m;
        m     = '1;
        m[2]  = w[11];
        m[4]  = w[10];
        m[8]  = w[9];
        m[11] = w[8];
        m[13] = w[7];
        m[17] = w[6];
        m[20] = w[5];
        m[22] = w[4];
        keep_mask = m;
    endfunction

endpackage

`default_nettype wire

>>> src/snl_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module snl_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire snl_pkg::cell_cmd_t cmd,
    input  wire logic              left,
    input  wire logic              keep,
    output logic                   q,
    output logic                   q_next
);

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (cmd.load_ones)
        begin
            bit_next = 1'b1;
        end
        else if (cmd.shift)
        begin
            bit_next = left;
        end
        else if (cmd.wb_clear)
        begin
            bit_next = bit_reg & keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b1;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign q      = bit_reg;
    assign q_next = bit_next;

endmodule

`default_nettype wire

>>> src/snl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module snl_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [1:0]                    op,
    input  wire logic [7:0]                    control,
    input  wire logic [snl_pkg::LFSR_W-1:0]    lfsr,
    output snl_pkg::cell_cmd_t                 cmd,
    output logic [snl_pkg::WAVE_W-1:0]         wave_next_out,
    output logic                               test_q
);

    logic [snl_pkg::WAVE_W-1:0]  wave_reg;
    logic [snl_pkg::WAVE_W-1:0]  wave_next;
    logic                        test_reg;
    logic                        test_next;
    logic [snl_pkg::COUNT_W-1:0] count_reg;
    logic [snl_pkg::COUNT_W-1:0] count_next;

    always_comb
    begin
        cmd        = '0;
        wave_next  = wave_reg;
        test_next  = test_reg;
        count_next = count_reg;
        if (accept)
        begin
            case (op)
                snl_pkg::OP_SHIFT:
                begin
                    cmd.shift = 1'b1;
                    cmd.feed  = lfsr[0] ^ lfsr[5];
                end
                snl_pkg::OP_CTRL:
                begin
                    wave_next = control[7:4];
                    test_next = control[snl_pkg::TEST_BIT];
                    if (test_next && !test_reg)
                    begin
                        count_next = snl_pkg::RESET_DELAY;
                    end
                    else if (!test_next && test_reg)
                    begin
                        cmd.shift = 1'b1;
                        cmd.feed  = ~lfsr[5];
                    end
                end
                snl_pkg::OP_WB:
                begin
                    cmd.wb_clear = 1'b1;
                end
                snl_pkg::OP_TICK:
                begin
                    if (test_reg && (count_reg != '0))
                    begin
                        count_next = count_reg - 1'b1;
                        if (count_next == '0)
                        begin
                            cmd.load_ones = 1'b1;
                        end
                    end
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg  <= '0;
            test_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wave_reg  <= wave_next;
            test_reg  <= test_next;
            count_reg <= count_next;
        end
    end

    assign wave_next_out = wave_next;
    assign test_q        = test_reg;

endmodule

`default_nettype wire

>>> src/sound_chip_noise_lfsr_top.sv
// Noise shift register of one sound chip voice.
// Input channel (in_valid/in_ready) carries one item: op selects shift clock,
// control write, combined waveform writeback or cycle tick; control and
// combined_output are the operands of the control write and the writeback.
// Output channel (out_valid/out_ready) returns one item per input item: the
// 12-bit noise word (forced to 0xfff unless noise is selected) and the 23-bit
// shift register, both as they stand after that input item.
// The register is a row of 23 one-bit cells; each cell takes its left
// neighbor on a shift, so every op completes in the cycle it is accepted.
// out_valid rises in the cycle after input accept. Throughput: 1 item per
// cycle while out_ready allows, set by the single output register stage.
// Reset: the register goes to all ones, waveform select, test and the reset
// countdown to zero, and the output register empties.
// Stall: while out_ready is low and a result is held, in_ready drops; no
// item is taken until the held result leaves, and it may leave and a new
// item enter in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module sound_chip_noise_lfsr_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     op,
    input  wire logic [7:0]                     control,
    input  wire logic [snl_pkg::NOISE_W-1:0]    combined_output,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [snl_pkg::NOISE_W-1:0]         noise_value,
    output logic [snl_pkg::LFSR_W-1:0]          register_value
);

    logic                         accept;
    snl_pkg::cell_cmd_t           cmd;
    logic [snl_pkg::WAVE_W-1:0]   wave_next;
    logic                         test_q;
    logic [snl_pkg::LFSR_W-1:0]   lfsr_q;
    logic [snl_pkg::LFSR_W-1:0]   lfsr_next;
    logic [snl_pkg::LFSR_W-1:0]   keep;
    logic [snl_pkg::LFSR_W-1:0]   left;

    logic                         valid_reg;
    logic                         valid_next;
    logic [snl_pkg::NOISE_W-1:0]  noise_reg;
    logic [snl_pkg::NOISE_W-1:0]  noise_next;
    logic [snl_pkg::LFSR_W-1:0]   value_reg;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign keep     = snl_pkg::keep_mask(combined_output);

    snl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op            (op),
        .control       (control),
        .lfsr          (lfsr_q),
        .cmd           (cmd),
        .wave_next_out (wave_next),
        .test_q        (test_q)
    );

    genvar i;
    generate
        for (i = 0; i < snl_pkg::LFSR_W; i++)
        begin : g_cell
            if (i == snl_pkg::LFSR_W - 1)
            begin : g_top
                assign left[i] = cmd.feed;
            end
            else
            begin : g_mid
                assign left[i] = lfsr_q[i+1];
            end

            snl_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (cmd),
                .left   (left[i]),
                .keep   (keep[i]),
                .q      (lfsr_q[i]),
                .q_next (lfsr_next[i])
            );
        end
    endgenerate

    always_comb
    begin
        noise_next = snl_pkg::gather_noise(lfsr_next);
        if (!wave_next[snl_pkg::NOISE_SEL])
        begin
            noise_next = snl_pkg::NOISE_OFF;
        end
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            noise_reg <= noise_next;
            value_reg <= lfsr_next;
        end
    end

    assign out_valid      = valid_reg;
    assign noise_value    = noise_reg;
    assign register_value = value_reg;

    a_shift_moves_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == snl_pkg::OP_SHIFT)
        |=> (lfsr_q[snl_pkg::LFSR_W-2:0] == $past(lfsr_q[snl_pkg::LFSR_W-1:1])))
        else $error("shift did not move the cell row right");

    a_test_rise_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == snl_pkg::OP_CTRL) && !test_q && control[snl_pkg::TEST_BIT]
        |=> $stable(lfsr_q))
        else $error("test rising edge changed the register");

    a_result_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (register_value == lfsr_q) && out_valid)
        else $error("result does not match the register row");

    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (valid_reg && !out_ready))
        else $error("input stalled without a held result");

endmodule

`default_nettype wire
